[sv/rsc_pkg.sv]
// Shared types and constants for the ray/sphere closest-hit block.
// Used by every module and interface of the block; depends on nothing.
package rsc_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int INDEX_W   = 16;
   localparam int T_W       = COORD_W - 1;
   localparam int V_W       = COORD_W + 1;
   // Dot products of three coordinate pairs need two bits of headroom plus sign.
   localparam int OPND_W    = 2 * COORD_W + 4;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ROOT_W    = OPND_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int NUM_W     = OPND_W + FRAC_BITS;
   localparam int STEP_W    = $clog2(NUM_W + 1);
   localparam int MUL_SHORT = V_W;
   localparam int MUL_LONG  = OPND_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [T_W-1:0] T_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_MUL, ST_ROOT, ST_DIFF, ST_DIV, ST_SAT, ST_DONE
   } back_state_type;

   typedef enum logic [3:0] {
      OP_S_X, OP_S_Y, OP_S_Z,
      OP_L_X, OP_L_Y, OP_L_Z,
      OP_A_X, OP_A_Y, OP_A_Z,
      OP_R2, OP_SS, OP_AC
   } mul_op_type;

   typedef struct packed {
      logic signed [V_W-1:0]     v_x;
      logic signed [V_W-1:0]     v_y;
      logic signed [V_W-1:0]     v_z;
      logic signed [COORD_W-1:0] d_x;
      logic signed [COORD_W-1:0] d_y;
      logic signed [COORD_W-1:0] d_z;
      logic [T_W-1:0]            radius;
      logic [INDEX_W-1:0]        prim_index;
      logic                      new_ray;
      logic                      dir_zero;
   } entry_type;

   typedef struct packed {
      logic                     start;
      logic signed [OPND_W-1:0] op_a;
      logic signed [OPND_W-1:0] op_b;
      logic [STEP_W-1:0]        steps;
   } mul_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic               this_hit;
      logic [T_W-1:0]     this_t;
      logic               any_hit_out;
      logic [T_W-1:0]     best_t_out;
      logic [INDEX_W-1:0] best_index_out;
   } rsp_payload_type;

endpackage

[sv/rsc_req_if.sv]
// Request channel: one ray/sphere test per transfer.
// Depends on rsc_pkg for field widths.
interface rsc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [rsc_pkg::COORD_W-1:0]        origin_x;
   logic signed [rsc_pkg::COORD_W-1:0]        origin_y;
   logic signed [rsc_pkg::COORD_W-1:0]        origin_z;
   logic signed [rsc_pkg::COORD_W-1:0]        dir_x;
   logic signed [rsc_pkg::COORD_W-1:0]        dir_y;
   logic signed [rsc_pkg::COORD_W-1:0]        dir_z;
   logic signed [rsc_pkg::COORD_W-1:0]        center_x;
   logic signed [rsc_pkg::COORD_W-1:0]        center_y;
   logic signed [rsc_pkg::COORD_W-1:0]        center_z;
   logic [rsc_pkg::T_W-1:0]                   radius;
   logic [rsc_pkg::INDEX_W-1:0]               prim_index;
   logic                                      new_ray;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   center_x, center_y, center_z, radius, prim_index, new_ray,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 center_x, center_y, center_z, radius, prim_index, new_ray,
                 output ready);
endinterface

[sv/rsc_rsp_if.sv]
// Response channel: one hit result and closest-hit record per transfer.
// Depends on rsc_pkg for field widths.
interface rsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        this_hit;
   logic [rsc_pkg::T_W-1:0]     this_t;
   logic                        any_hit_out;
   logic [rsc_pkg::T_W-1:0]     best_t_out;
   logic [rsc_pkg::INDEX_W-1:0] best_index_out;

   modport source (output valid, this_hit, this_t, any_hit_out, best_t_out,
                   best_index_out, input ready);
   modport sink (input valid, this_hit, this_t, any_hit_out, best_t_out,
                 best_index_out, output ready);
endinterface

[sv/rsc_front.sv]
// Front end: accepts requests, forms center minus origin and flags a zero direction.
// Depends on rsc_pkg and rsc_req_if.
module rsc_front (
   rsc_req_if.sink              req_ch,
   input  logic                 q_full,
   output logic                 q_push,
   output rsc_pkg::entry_type   q_entry
);

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   always_comb begin
      q_entry.v_x = rsc_pkg::V_W'(req_ch.center_x) - rsc_pkg::V_W'(req_ch.origin_x);
      q_entry.v_y = rsc_pkg::V_W'(req_ch.center_y) - rsc_pkg::V_W'(req_ch.origin_y);
      q_entry.v_z = rsc_pkg::V_W'(req_ch.center_z) - rsc_pkg::V_W'(req_ch.origin_z);
      q_entry.d_x = req_ch.dir_x;
      q_entry.d_y = req_ch.dir_y;
      q_entry.d_z = req_ch.dir_z;
      q_entry.radius     = req_ch.radius;
      q_entry.prim_index = req_ch.prim_index;
      q_entry.new_ray    = req_ch.new_ray;
      // A zero direction can never hit, so the back end skips the arithmetic.
      q_entry.dir_zero = (req_ch.dir_x == '0) && (req_ch.dir_y == '0) &&
                         (req_ch.dir_z == '0);
   end

endmodule

[sv/rsc_queue.sv]
// Short FIFO between the front end and the back end.
// Depends on rsc_pkg.
module rsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsc_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               avail,
   output rsc_pkg::entry_type head
);

   rsc_pkg::entry_type               entries_ff [rsc_pkg::QUEUE_DEPTH];
   logic [rsc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rsc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rsc_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [rsc_pkg::QCNT_W-1:0] QCNT_one(input logic bit_in);
      QCNT_one = {{(rsc_pkg::QCNT_W-1){1'b0}}, bit_in};
   endfunction

   assign full  = (count_ff == rsc_pkg::QCNT_W'(rsc_pkg::QUEUE_DEPTH));
   assign avail = (count_ff != '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_one(push) - QCNT_one(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/rsc_mul.sv]
// Serial signed multiplier, one multiplier bit per cycle on magnitudes.
// Depends on rsc_pkg.
module rsc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rsc_pkg::mul_req_type mul_req,
   output rsc_pkg::mul_rsp_type mul_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [rsc_pkg::PROD_W-1:0]        mcand_ff, mcand_in;
   logic [rsc_pkg::OPND_W-1:0]        mplier_ff, mplier_in;
   logic [rsc_pkg::PROD_W-1:0]        acc_ff, acc_in;
   logic [rsc_pkg::STEP_W-1:0]        steps_ff, steps_in;
   logic [rsc_pkg::OPND_W-1:0]        mag_a, mag_b;

   always_comb begin
      mag_a = mul_req.op_a[rsc_pkg::OPND_W-1] ? -mul_req.op_a : mul_req.op_a;
      mag_b = mul_req.op_b[rsc_pkg::OPND_W-1] ? -mul_req.op_b : mul_req.op_b;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      steps_in  = steps_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         neg_in    = mul_req.op_a[rsc_pkg::OPND_W-1] ^ mul_req.op_b[rsc_pkg::OPND_W-1];
         mcand_in  = rsc_pkg::PROD_W'(mag_a);
         mplier_in = mag_b;
         acc_in    = '0;
         steps_in  = mul_req.steps;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         steps_in  = steps_ff - 1'b1;
         if (steps_ff == rsc_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      steps_ff  <= steps_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

[sv/rsc_back.sv]
// Back end: sequences the quadratic solve, keeps the closest-hit record
// and holds the response register. Depends on rsc_pkg and rsc_rsp_if.
module rsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_avail,
   input  rsc_pkg::entry_type   q_head,
   output logic                 q_pop,
   output rsc_pkg::mul_req_type mul_req,
   input  rsc_pkg::mul_rsp_type mul_rsp,
   rsc_rsp_if.source            rsp_ch
);

   rsc_pkg::back_state_type          state_ff, state_in;
   rsc_pkg::mul_op_type              op_ff, op_in;
   rsc_pkg::entry_type               item_ff, item_in;
   logic signed [rsc_pkg::OPND_W-1:0] s_ff, s_in, l_ff, l_in, a_ff, a_in;
   logic signed [rsc_pkg::PROD_W-1:0] ss_ff, ss_in;
   logic [rsc_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [rsc_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic [rsc_pkg::PROD_W-1:0]       rad_ff, rad_in;
   logic [rsc_pkg::NUM_W-1:0]        num_ff, num_in, quo_ff, quo_in;
   logic [rsc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             hit_ff, hit_in;
   logic [rsc_pkg::T_W-1:0]          t_ff, t_in;
   logic                             any_ff, any_in;
   logic [rsc_pkg::T_W-1:0]          best_t_ff, best_t_in;
   logic [rsc_pkg::INDEX_W-1:0]      best_idx_ff, best_idx_in;
   logic                             out_valid_ff, out_valid_in;
   rsc_pkg::rsp_payload_type         out_ff, out_in;

   logic signed [rsc_pkg::OPND_W-1:0] prod_lo;
   logic signed [rsc_pkg::PROD_W-1:0] q_disc;
   logic signed [rsc_pkg::OPND_W+1:0] n_diff;
   logic [rsc_pkg::REM_W-1:0]        rem_sh, root_trial, div_sh, div_a;
   logic                             out_free;

   assign prod_lo    = mul_rsp.product[rsc_pkg::OPND_W-1:0];
   assign q_disc     = ss_ff - mul_rsp.product;
   assign n_diff     = (rsc_pkg::OPND_W+2)'(s_ff) - $signed({2'b00, root_ff});
   assign rem_sh     = {rem_ff[rsc_pkg::ROOT_W:0], rad_ff[rsc_pkg::PROD_W-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign div_sh     = {rem_ff[rsc_pkg::REM_W-2:0], num_ff[rsc_pkg::NUM_W-1]};
   assign div_a      = {3'b000, a_ff};
   assign out_free   = !out_valid_ff || rsp_ch.ready;

   // Operand select for the shared multiplier.
   always_comb begin
      mul_req.start = (state_ff == rsc_pkg::ST_ISSUE);
      mul_req.steps = rsc_pkg::STEP_W'(rsc_pkg::MUL_SHORT);
      case (op_ff)
         rsc_pkg::OP_S_X: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_x);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_x);
         end
         rsc_pkg::OP_S_Y: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_y);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_y);
         end
         rsc_pkg::OP_S_Z: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_z);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_z);
         end
         rsc_pkg::OP_L_X: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_x);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.v_x);
         end
         rsc_pkg::OP_L_Y: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_y);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.v_y);
         end
         rsc_pkg::OP_L_Z: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.v_z);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.v_z);
         end
         rsc_pkg::OP_A_X: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.d_x);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_x);
         end
         rsc_pkg::OP_A_Y: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.d_y);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_y);
         end
         rsc_pkg::OP_A_Z: begin
            mul_req.op_a = rsc_pkg::OPND_W'(item_ff.d_z);
            mul_req.op_b = rsc_pkg::OPND_W'(item_ff.d_z);
         end
         rsc_pkg::OP_R2: begin
            mul_req.op_a = $signed(rsc_pkg::OPND_W'(item_ff.radius));
            mul_req.op_b = $signed(rsc_pkg::OPND_W'(item_ff.radius));
         end
         rsc_pkg::OP_SS: begin
            mul_req.op_a  = s_ff;
            mul_req.op_b  = s_ff;
            mul_req.steps = rsc_pkg::STEP_W'(rsc_pkg::MUL_LONG);
         end
         rsc_pkg::OP_AC: begin
            mul_req.op_a  = l_ff;
            mul_req.op_b  = a_ff;
            mul_req.steps = rsc_pkg::STEP_W'(rsc_pkg::MUL_LONG);
         end
         default: begin
            mul_req.op_a = '0;
            mul_req.op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      s_in         = s_ff;
      l_in         = l_ff;
      a_in         = a_ff;
      ss_in        = ss_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rad_in       = rad_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      t_in         = t_ff;
      any_in       = any_ff;
      best_t_in    = best_t_ff;
      best_idx_in  = best_idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      q_pop        = 1'b0;
      case (state_ff)
         rsc_pkg::ST_IDLE: begin
            if (q_avail) begin
               q_pop   = 1'b1;
               item_in = q_head;
               s_in    = '0;
               l_in    = '0;
               a_in    = '0;
               op_in   = rsc_pkg::OP_S_X;
               if (q_head.dir_zero) begin
                  hit_in   = 1'b0;
                  t_in     = '0;
                  state_in = rsc_pkg::ST_DONE;
               end else begin
                  state_in = rsc_pkg::ST_ISSUE;
               end
            end
         end
         rsc_pkg::ST_ISSUE: begin
            state_in = rsc_pkg::ST_MUL;
         end
         rsc_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               state_in = rsc_pkg::ST_ISSUE;
               op_in    = rsc_pkg::mul_op_type'(op_ff + 1'b1);
               case (op_ff)
                  rsc_pkg::OP_S_X, rsc_pkg::OP_S_Y, rsc_pkg::OP_S_Z: begin
                     s_in = s_ff + prod_lo;
                  end
                  rsc_pkg::OP_L_X, rsc_pkg::OP_L_Y, rsc_pkg::OP_L_Z: begin
                     l_in = l_ff + prod_lo;
                  end
                  rsc_pkg::OP_A_X, rsc_pkg::OP_A_Y, rsc_pkg::OP_A_Z: begin
                     a_in = a_ff + prod_lo;
                  end
                  rsc_pkg::OP_R2: begin
                     // From here on l holds C = L - R2.
                     l_in = l_ff - prod_lo;
                     if (s_ff < 0 && l_in > 0) begin
                        hit_in   = 1'b0;
                        t_in     = '0;
                        state_in = rsc_pkg::ST_DONE;
                     end
                  end
                  rsc_pkg::OP_SS: begin
                     ss_in = mul_rsp.product;
                     // Closest approach lies beyond the radius.
                     if ((rsc_pkg::PROD_W'(l_ff) <<< (2 * rsc_pkg::FRAC_BITS)) >
                         mul_rsp.product) begin
                        hit_in   = 1'b0;
                        t_in     = '0;
                        state_in = rsc_pkg::ST_DONE;
                     end
                  end
                  rsc_pkg::OP_AC: begin
                     if (q_disc < 0) begin
                        hit_in   = 1'b0;
                        t_in     = '0;
                        state_in = rsc_pkg::ST_DONE;
                     end else begin
                        rad_in   = q_disc;
                        rem_in   = '0;
                        root_in  = '0;
                        step_in  = rsc_pkg::STEP_W'(rsc_pkg::ROOT_W);
                        state_in = rsc_pkg::ST_ROOT;
                     end
                  end
                  default: begin
                     state_in = rsc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         rsc_pkg::ST_ROOT: begin
            // One root bit per cycle from the top pair of radicand bits down.
            if (rem_sh >= root_trial) begin
               rem_in  = rem_sh - root_trial;
               root_in = {root_ff[rsc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[rsc_pkg::ROOT_W-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff - 1'b1;
            if (step_ff == rsc_pkg::STEP_W'(1)) begin
               state_in = rsc_pkg::ST_DIFF;
            end
         end
         rsc_pkg::ST_DIFF: begin
            if (n_diff <= 0) begin
               hit_in   = 1'b0;
               t_in     = '0;
               state_in = rsc_pkg::ST_DONE;
            end else begin
               num_in   = {n_diff[rsc_pkg::OPND_W-1:0], {rsc_pkg::FRAC_BITS{1'b0}}};
               quo_in   = '0;
               rem_in   = '0;
               step_in  = rsc_pkg::STEP_W'(rsc_pkg::NUM_W);
               state_in = rsc_pkg::ST_DIV;
            end
         end
         rsc_pkg::ST_DIV: begin
            if (div_sh >= div_a) begin
               rem_in = div_sh - div_a;
               quo_in = {quo_ff[rsc_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_sh;
               quo_in = {quo_ff[rsc_pkg::NUM_W-2:0], 1'b0};
            end
            num_in  = num_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == rsc_pkg::STEP_W'(1)) begin
               state_in = rsc_pkg::ST_SAT;
            end
         end
         rsc_pkg::ST_SAT: begin
            if (quo_ff > rsc_pkg::NUM_W'(rsc_pkg::T_MAX)) begin
               t_in = rsc_pkg::T_MAX;
            end else begin
               t_in = quo_ff[rsc_pkg::T_W-1:0];
            end
            // A positive root that truncates to zero counts as a miss.
            hit_in   = (t_in != '0);
            state_in = rsc_pkg::ST_DONE;
         end
         rsc_pkg::ST_DONE: begin
            if (out_free) begin
               if (item_ff.new_ray) begin
                  any_in      = 1'b0;
                  best_t_in   = '0;
                  best_idx_in = '0;
               end
               if (hit_ff) begin
                  // On a tie the older record stays.
                  if (!any_in || t_ff < best_t_in) begin
                     best_t_in   = t_ff;
                     best_idx_in = item_ff.prim_index;
                  end
                  any_in = 1'b1;
               end
               out_in.this_hit       = hit_ff;
               out_in.this_t         = t_ff;
               out_in.any_hit_out    = any_in;
               out_in.best_t_out     = best_t_in;
               out_in.best_index_out = best_idx_in;
               out_valid_in = 1'b1;
               state_in     = rsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
         best_t_ff    <= '0;
         best_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         any_ff       <= any_in;
         best_t_ff    <= best_t_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      item_ff <= item_in;
      s_ff    <= s_in;
      l_ff    <= l_in;
      a_ff    <= a_in;
      ss_ff   <= ss_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      hit_ff  <= hit_in;
      t_ff    <= t_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.this_hit       = out_ff.this_hit;
   assign rsp_ch.this_t         = out_ff.this_t;
   assign rsp_ch.any_hit_out    = out_ff.any_hit_out;
   assign rsp_ch.best_t_out     = out_ff.best_t_out;
   assign rsp_ch.best_index_out = out_ff.best_index_out;

   a_hit_sets_record: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.this_hit |-> out_ff.any_hit_out)
      else $error("hit transferred without a recorded hit");

   a_hit_has_distance: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.this_hit == (out_ff.this_t != '0)))
      else $error("hit flag disagrees with distance");

   a_record_nonzero: assert property (@(posedge clock) disable iff (reset)
      any_ff |-> (best_t_ff != '0))
      else $error("record holds a hit at zero distance");

   a_mul_idle_on_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsc_pkg::ST_ISSUE |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

endmodule

[sv/ray_sphere_closest_hit.sv]
// Ray/sphere closest-hit block: top level tying front end, queue, multiplier and back end.
// Depends on rsc_pkg, rsc_req_if, rsc_rsp_if, rsc_front, rsc_queue, rsc_mul, rsc_back.
//
// Each request transfer tests one ray against one sphere (signed Q16.16) and yields one
// response with this test's hit and distance plus the closest-hit record, which new_ray
// clears before the test. Throughput is one item at a time through the back end: a zero
// direction goes from the queue to the done state and then to the response register; a
// full solve runs ten passes over 33 multiplier bits and two over 68 on the single
// bit-serial multiplier, each through the issue and multiply states, then a square root
// of 68 root bits, a divide of 84 quotient bits and the difference, saturate and done
// states. Rejects decided by a multiply end the item after that multiply, and a non-positive
// nearer root ends it after the square root. A two-entry queue lets requests keep arriving
// while the back end works, and the response register holds a result until it is taken.
module ray_sphere_closest_hit (
   input  logic       clock,
   input  logic       reset,
   rsc_req_if.sink    req_ch,
   rsc_rsp_if.source  rsp_ch
);

   logic                 q_full;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_avail;
   rsc_pkg::entry_type   q_entry;
   rsc_pkg::entry_type   q_head;
   rsc_pkg::mul_req_type mul_req;
   rsc_pkg::mul_rsp_type mul_rsp;

   rsc_front u_front (
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   rsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .avail      (q_avail),
      .head       (q_head)
   );

   rsc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   rsc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_avail (q_avail),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp),
      .rsp_ch  (rsp_ch)
   );

endmodule

[test/rsc_tb_if.sv]
`timescale 1ns / 1ps
// Testbench-side type for one ray/sphere test item.
// Depends on rsc_pkg for field widths.
package rsc_tb_pkg;

   typedef struct {
      logic signed [rsc_pkg::COORD_W-1:0] org [3];
      logic signed [rsc_pkg::COORD_W-1:0] dir [3];
      logic signed [rsc_pkg::COORD_W-1:0] ctr [3];
      logic [rsc_pkg::T_W-1:0]            radius;
      logic [rsc_pkg::INDEX_W-1:0]        prim_index;
      logic                               new_ray;
   } ray_test_type;
endpackage

[test/tb_ray_sphere_closest_hit.sv]
`timescale 1ns / 1ps
// Testbench for ray_sphere_closest_hit: a queue-fed driver, a response monitor and a
// predictor that solves each ray/sphere test with exact wide integers.
// Depends on rsc_pkg, rsc_tb_pkg, rsc_req_if, rsc_rsp_if and the block itself.
module tb_ray_sphere_closest_hit;

   localparam int WIDE = 320;
   typedef logic signed [WIDE-1:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   ray_sphere_closest_hit dut (.clock(clock), .reset(reset), .req_ch(req_ch),
                               .rsp_ch(rsp_ch));

   always #5 clock = ~clock;

   rsc_tb_pkg::ray_test_type pending_tests [$];
   rsc_pkg::rsp_payload_type expected_hits [$];

   logic                        rec_any_hit = 1'b0;
   logic [rsc_pkg::T_W-1:0]     rec_best_t = '0;
   logic [rsc_pkg::INDEX_W-1:0] rec_best_index = '0;

   int mismatch_count = 0;
   int hits_seen = 0;
   int results_seen = 0;
   bit quiet_mode = 1'b0;
   bit hold_off = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int take_gap = 0;
   int rays_sent = 0;

   function automatic wide_type isqrt_wide(wide_type x);
      wide_type root;
      wide_type cand;
      root = '0;
      for (int b = WIDE / 2 - 2; b >= 0; b--) begin
         cand = root | (wide_type'(1) << b);
         if (cand * cand <= x) root = cand;
      end
      return root;
   endfunction

   // Distance of the nearer root in unsigned Q15.16, zero on a miss.
   function automatic logic [rsc_pkg::T_W-1:0] nearer_root(rsc_tb_pkg::ray_test_type r);
      wide_type s, l, a, c, q, n, t, v, d;
      s = '0;
      l = '0;
      a = '0;
      for (int i = 0; i < 3; i++) begin
         v = wide_type'(r.ctr[i]) - wide_type'(r.org[i]);
         d = wide_type'(r.dir[i]);
         s += v * d;
         l += v * v;
         a += d * d;
      end
      c = l - wide_type'({1'b0, r.radius}) * wide_type'({1'b0, r.radius});
      if (s < 0 && c > 0) return '0;
      if ((c <<< (2 * rsc_pkg::FRAC_BITS)) > s * s) return '0;
      if (a == 0) return '0;
      q = s * s - a * c;
      if (q < 0) return '0;
      n = s - isqrt_wide(q);
      if (n <= 0) return '0;
      t = (n <<< rsc_pkg::FRAC_BITS) / a;
      if (t > wide_type'({1'b0, rsc_pkg::T_MAX})) return rsc_pkg::T_MAX;
      return t[rsc_pkg::T_W-1:0];
   endfunction

   task automatic predict_closest_hit(rsc_tb_pkg::ray_test_type r);
      rsc_pkg::rsp_payload_type e;
      e.this_t = nearer_root(r);
      e.this_hit = e.this_t != 0;
      if (r.new_ray) begin
         rec_any_hit = 1'b0;
         rec_best_t = '0;
         rec_best_index = '0;
      end
      if (e.this_hit) begin
         if (!rec_any_hit || e.this_t < rec_best_t) begin
            rec_best_t = e.this_t;
            rec_best_index = r.prim_index;
         end
         rec_any_hit = 1'b1;
      end
      e.any_hit_out = rec_any_hit;
      e.best_t_out = rec_best_t;
      e.best_index_out = rec_best_index;
      expected_hits.push_back(e);
   endtask

   function automatic logic signed [rsc_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      endcase
   endfunction

   // Mostly rays aimed near a sphere so that hits, grazes and inside cases come up.
   function automatic rsc_tb_pkg::ray_test_type random_test(bit first_of_ray);
      rsc_tb_pkg::ray_test_type r;
      for (int i = 0; i < 3; i++) begin
         r.org[i] = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.ctr[i] = r.org[i] + ($signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000);
         r.dir[i] = (r.ctr[i] - r.org[i]) + ($signed($urandom_range(0, 32'h0003ffff))
                    - 32'sh00020000);
      end
      r.radius = rsc_pkg::T_W'($urandom_range(0, 32'h00200000));
      if ($urandom_range(0, 9) == 0) begin
         for (int i = 0; i < 3; i++) begin
            r.org[i] = rand_coord();
            r.dir[i] = rand_coord();
            r.ctr[i] = rand_coord();
         end
         r.radius = rsc_pkg::T_W'($urandom);
      end
      if ($urandom_range(0, 19) == 0) r.dir[$urandom_range(0, 2)] = -r.dir[0];
      r.prim_index = rsc_pkg::INDEX_W'($urandom);
      r.new_ray = first_of_ray;
      return r;
   endfunction

   function automatic rsc_tb_pkg::ray_test_type unit_test(int ox, int dx, int cx, int rad,
                                                          int idx, bit nr);
      rsc_tb_pkg::ray_test_type r;
      for (int i = 0; i < 3; i++) begin
         r.org[i] = '0;
         r.dir[i] = '0;
         r.ctr[i] = '0;
      end
      r.org[0] = ox;
      r.dir[0] = dx;
      r.ctr[0] = cx;
      r.radius = rsc_pkg::T_W'(rad);
      r.prim_index = rsc_pkg::INDEX_W'(idx);
      r.new_ray = nr;
      return r;
   endfunction

   task automatic queue_test(rsc_tb_pkg::ray_test_type r);
      pending_tests.push_back(r);
      rays_sent++;
   endtask

   // Driver: offers the head of the queue, with random gaps. An offered transfer is
   // held unchanged until the block accepts it.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_tests.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 4);
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               req_ch.origin_x <= pending_tests[0].org[0];
               req_ch.origin_y <= pending_tests[0].org[1];
               req_ch.origin_z <= pending_tests[0].org[2];
               req_ch.dir_x <= pending_tests[0].dir[0];
               req_ch.dir_y <= pending_tests[0].dir[1];
               req_ch.dir_z <= pending_tests[0].dir[2];
               req_ch.center_x <= pending_tests[0].ctr[0];
               req_ch.center_y <= pending_tests[0].ctr[1];
               req_ch.center_z <= pending_tests[0].ctr[2];
               req_ch.radius <= pending_tests[0].radius;
               req_ch.prim_index <= pending_tests[0].prim_index;
               req_ch.new_ray <= pending_tests[0].new_ray;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         take_gap <= $urandom_range(0, 4);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Long receiver hold-off right after reset while requests keep coming.
   initial begin
      wait (!reset);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   // Request monitor retires the driven item and feeds the predictor on each transfer.
   always @(posedge clock) begin
      rsc_tb_pkg::ray_test_type r;
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (req_taken) begin
         void'(pending_tests.pop_front());
         r.org[0] = req_ch.origin_x;
         r.org[1] = req_ch.origin_y;
         r.org[2] = req_ch.origin_z;
         r.dir[0] = req_ch.dir_x;
         r.dir[1] = req_ch.dir_y;
         r.dir[2] = req_ch.dir_z;
         r.ctr[0] = req_ch.center_x;
         r.ctr[1] = req_ch.center_y;
         r.ctr[2] = req_ch.center_z;
         r.radius = req_ch.radius;
         r.prim_index = req_ch.prim_index;
         r.new_ray = req_ch.new_ray;
         predict_closest_hit(r);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      rsc_pkg::rsp_payload_type got;
      rsc_pkg::rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.this_hit = rsp_ch.this_hit;
         got.this_t = rsp_ch.this_t;
         got.any_hit_out = rsp_ch.any_hit_out;
         got.best_t_out = rsp_ch.best_t_out;
         got.best_index_out = rsp_ch.best_index_out;
         results_seen++;
         if (expected_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_hits.pop_front();
            if (got.this_hit) hits_seen++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d mismatch: expected %p, got %p", results_seen,
                           want, got);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("tb_ray_sphere_closest_hit failed");
      $finish;
   end

   initial begin
      bit first;
      req_ch.valid = 1'b0;
      req_ch.origin_x = '0;
      req_ch.origin_y = '0;
      req_ch.origin_z = '0;
      req_ch.dir_x = '0;
      req_ch.dir_y = '0;
      req_ch.dir_z = '0;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.center_z = '0;
      req_ch.radius = '0;
      req_ch.prim_index = '0;
      req_ch.new_ray = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: plain hit, equal distance, nearer hit, zero direction, pointing away,
      // inside sphere, tiny root, saturation, graze, extremes.
      queue_test(unit_test(0, 32'h10000, 32'h50000, 32'h10000, 1, 1));
      queue_test(unit_test(0, 32'h10000, 32'h50000, 32'h10000, 2, 0));
      queue_test(unit_test(0, 32'h10000, 32'h30000, 32'h10000, 3, 0));
      queue_test(unit_test(0, 32'h10000, 32'h90000, 32'h10000, 4, 0));
      queue_test(unit_test(0, 0, 32'h50000, 32'h10000, 5, 0));
      queue_test(unit_test(0, -32'sh10000, 32'h50000, 32'h10000, 6, 0));
      queue_test(unit_test(0, 32'h10000, 32'h0, 32'h20000, 7, 0));
      queue_test(unit_test(0, 32'h7fffffff, 32'h1, 32'h0, 8, 1));
      queue_test(unit_test(0, 1, 32'h7fff0000, 32'h10000, 9, 1));
      queue_test(unit_test(0, 32'h10000, 32'h50000, 32'h0, 10, 0));
      queue_test(unit_test(32'sh80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           16'hffff, 1));
      queue_test(unit_test(32'h7fffffff, 32'sh80000000, 32'sh80000000, 32'h7fffffff,
                           0, 0));
      queue_test(unit_test(32'hffff, 32'h10000, 32'h50000, 32'h7fffffff, 16'h5555, 1));
      queue_test(unit_test(0, 32'h10000, 32'h2, 32'h1, 16'haaaa, 1));
      queue_test(unit_test(0, 32'h1, 32'h50000, 32'h10000, 11, 0));

      for (int i = 0; i < 6; i++) queue_test(random_test(i == 0));

      first = 1'b1;
      for (int i = 0; i < 1880; i++) begin
         if (i == 1500) begin
            while (pending_tests.size() > 0) @(posedge clock);
            quiet_mode = 1'b1;
         end
         queue_test(random_test(first));
         first = $urandom_range(0, 5) == 0;
         while (pending_tests.size() > 8) @(posedge clock);
      end

      while (pending_tests.size() > 0 || expected_hits.size() > 0) @(posedge clock);
      repeat (800) @(posedge clock);
      $display("Sent %0d ray/sphere tests and checked %0d results, %0d of them hits.",
               rays_sent, results_seen, hits_seen);
      if (mismatch_count == 0 && expected_hits.size() == 0)
         $display("tb_ray_sphere_closest_hit passed");
      else
         $display("tb_ray_sphere_closest_hit failed");
      $finish;
   end
endmodule

[sim.f]
sv/rsc_pkg.sv
sv/rsc_req_if.sv
sv/rsc_rsp_if.sv
sv/rsc_front.sv
sv/rsc_queue.sv
sv/rsc_mul.sv
sv/rsc_back.sv
sv/ray_sphere_closest_hit.sv
test/rsc_tb_if.sv
test/tb_ray_sphere_closest_hit.sv
